>>> rtl/msl_pkg.sv
// ---------------------------------------------------------------------------
// msl_pkg
// Shared types, constants and corner selection for the mirror segment locator.
// ---------------------------------------------------------------------------
package msl_pkg;

   localparam int NUM_MIRRORS        = 25;
   localparam int CORNERS_PER_MIRROR = 6;
   localparam int COORD_FRAC_BITS    = 8;

   localparam int COORD_W  = 24;
   localparam int MIRROR_W = 5;
   localparam int VERTEX_W = 3;

   localparam int MIRROR_STRIDE = CORNERS_PER_MIRROR * 2;
   localparam int TABLE_DEPTH   = NUM_MIRRORS * MIRROR_STRIDE;
   localparam int ADDR_W        = $clog2(TABLE_DEPTH);

   localparam int DIFF_W = COORD_W + 1;
   localparam int C_W    = 2 * DIFF_W + 1;
   localparam int HALF_W = 26;
   localparam int E_W    = 2 * HALF_W;
   localparam int MUL_W  = HALF_W + 1;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = 2 * E_W + 2;
   localparam int X2_W   = COORD_W + 2;

   localparam int SQ_SHIFT   = 2 * (COORD_FRAC_BITS + 2);
   localparam int MARGIN2    = 8 << COORD_FRAC_BITS;
   localparam int SH_HALF_N  = HALF_W + 1;
   localparam int SH_FULL_N  = 2 * HALF_W;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [MIRROR_W-1:0] SKIP_A      = MIRROR_W'(0);
   localparam logic [MIRROR_W-1:0] SKIP_B      = MIRROR_W'(7);
   localparam logic [MIRROR_W-1:0] SKIP_C      = MIRROR_W'(18);
   localparam logic [MIRROR_W-1:0] SKIP_D      = MIRROR_W'(19);
   localparam logic [MIRROR_W-1:0] AXIS_MIRROR = MIRROR_W'(2);
   localparam logic [MIRROR_W-1:0] QUAD_LO     = MIRROR_W'(23);
   localparam logic [MIRROR_W-1:0] QUAD_HI     = MIRROR_W'(24);
   localparam logic [MIRROR_W-1:0] LAST_MIRROR = MIRROR_W'(NUM_MIRRORS - 1);

   localparam logic [2:0] HEX_X_JOB  = 3'd4;
   localparam logic [2:0] QUAD_X_JOB = 3'd2;

   typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_type;
   typedef enum logic [1:0] {SH_NONE, SH_HALF, SH_FULL} acc_shift_type;

   typedef struct packed {
      logic                     mul_en;
      logic                     acc_en;
      acc_op_type               op;
      acc_shift_type            shift;
      logic signed [MUL_W-1:0]  opa;
      logic signed [MUL_W-1:0]  opb;
   } mac_ctrl_type;

   typedef struct packed {
      logic                      start;
      logic signed [COORD_W-1:0] query_x;
      logic signed [COORD_W-1:0] query_y;
      logic                      edge_flag;
   } seq_cmd_type;

   typedef struct packed {
      logic                done;
      logic                hit;
      logic [MIRROR_W-1:0] mirror_id;
   } seq_res_type;

   // corner fetched into a slot; lines use slots a.x a.y b.x b.y
   function automatic logic [VERTEX_W-1:0] corner_sel(input logic quad,
                                                      input logic [2:0] job,
                                                      input logic [1:0] slot);
      logic [VERTEX_W-1:0] a;
      logic [VERTEX_W-1:0] b;
      logic [VERTEX_W-1:0] c2;
      logic [VERTEX_W-1:0] c3;
      a  = 3'd0;
      b  = 3'd0;
      c2 = 3'd1;
      c3 = 3'd2;
      if (quad) begin
         case (job)
            3'd0:    begin a = 3'd1; b = 3'd0; end
            3'd1:    begin a = 3'd3; b = 3'd2; end
            default: begin a = 3'd0; b = 3'd3; end
         endcase
      end else begin
         case (job)
            3'd0:    begin a = 3'd0; b = 3'd1; end
            3'd1:    begin a = 3'd2; b = 3'd3; end
            3'd2:    begin a = 3'd3; b = 3'd4; end
            3'd3:    begin a = 3'd5; b = 3'd0; end
            default: begin a = 3'd4; b = 3'd5; end
         endcase
      end
      if ((quad && job == QUAD_X_JOB) || (!quad && job == HEX_X_JOB)) begin
         case (slot)
            2'd0:    corner_sel = a;
            2'd1:    corner_sel = b;
            2'd2:    corner_sel = c2;
            default: corner_sel = c3;
         endcase
      end else begin
         corner_sel = slot[1] ? b : a;
      end
   endfunction

   // point must lie below the line (else above)
   function automatic logic line_below(input logic quad, input logic [2:0] job);
      line_below = (job == 3'd0) || (!quad && job == 3'd3);
   endfunction

endpackage

>>> rtl/msl_if.sv
// ---------------------------------------------------------------------------
// msl_if
// Valid/ready channels for query and load words and for result words.
// ---------------------------------------------------------------------------
interface msl_req_if;
   logic                               valid;
   logic                               ready;
   logic                               func;
   logic [msl_pkg::MIRROR_W-1:0]       mirror_index;
   logic [msl_pkg::VERTEX_W-1:0]       vertex_index;
   logic                               axis_select;
   logic signed [msl_pkg::COORD_W-1:0] load_value;
   logic signed [msl_pkg::COORD_W-1:0] query_x;
   logic signed [msl_pkg::COORD_W-1:0] query_y;
   logic                               edge_flag;

   modport source (output valid, func, mirror_index, vertex_index, axis_select,
                   load_value, query_x, query_y, edge_flag, input ready);
   modport sink   (input valid, func, mirror_index, vertex_index, axis_select,
                   load_value, query_x, query_y, edge_flag, output ready);
endinterface

interface msl_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         hit;
   logic [msl_pkg::MIRROR_W-1:0] mirror_id;

   modport source (output valid, hit, mirror_id, input ready);
   modport sink   (input valid, hit, mirror_id, output ready);
endinterface

>>> rtl/msl_ram.sv
// ---------------------------------------------------------------------------
// msl_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module msl_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 300
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/msl_mac.sv
// ---------------------------------------------------------------------------
// msl_mac
// Shared signed multiplier with registered product and shifting accumulator.
// ---------------------------------------------------------------------------
module msl_mac (
   input  logic                              clock,
   input  msl_pkg::mac_ctrl_type             ctrl,
   output logic signed [msl_pkg::ACC_W-1:0]  acc
);

   logic signed [msl_pkg::PROD_W-1:0] prod_ff;
   logic signed [msl_pkg::PROD_W-1:0] prod_in;
   logic signed [msl_pkg::ACC_W-1:0]  acc_ff;
   logic signed [msl_pkg::ACC_W-1:0]  acc_in;
   logic signed [msl_pkg::ACC_W-1:0]  prod_ext;
   logic signed [msl_pkg::ACC_W-1:0]  term;

   assign prod_in  = ctrl.opa * ctrl.opb;
   assign prod_ext = msl_pkg::ACC_W'(prod_ff);

   always_comb begin
      case (ctrl.shift)
         msl_pkg::SH_HALF: term = prod_ext <<< msl_pkg::SH_HALF_N;
         msl_pkg::SH_FULL: term = prod_ext <<< msl_pkg::SH_FULL_N;
         default:          term = prod_ext;
      endcase
      case (ctrl.op)
         msl_pkg::ACC_ADD: acc_in = acc_ff + term;
         msl_pkg::ACC_SUB: acc_in = acc_ff - term;
         default:          acc_in = term;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctrl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

>>> rtl/msl_seq.sv
// ---------------------------------------------------------------------------
// msl_seq
// Query sequencer: walks the mirrors, fetches corners and runs edge tests.
// ---------------------------------------------------------------------------
module msl_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  msl_pkg::seq_cmd_type              cmd,
   input  logic                              res_free,
   output msl_pkg::seq_res_type              res,
   output logic                              busy,
   output logic [msl_pkg::ADDR_W-1:0]        rd_addr,
   input  logic [msl_pkg::COORD_W-1:0]       rd_data,
   output msl_pkg::mac_ctrl_type             mac_ctrl,
   input  logic signed [msl_pkg::ACC_W-1:0]  acc
);

   typedef enum logic [3:0] {
      S_IDLE, S_NEXT, S_FETCH, S_PREP, S_MUL, S_ACC, S_EVAL, S_XCHK, S_DONE
   } state_type;

   typedef enum logic [2:0] {K_CY, K_CX, K_DD, K_YY, K_HH, K_HL, K_LL} step_type;

   state_type                             state_ff, state_in;
   step_type                              step_ff, step_in;
   logic [msl_pkg::MIRROR_W-1:0]          mirror_ff, mirror_in;
   logic [msl_pkg::ADDR_W-1:0]            base_ff, base_in;
   logic [2:0]                            job_ff, job_in;
   logic [2:0]                            fcnt_ff, fcnt_in;
   logic signed [msl_pkg::COORD_W-1:0]    slot_ff [4];
   logic signed [msl_pkg::COORD_W-1:0]    slot_in [4];
   logic signed [msl_pkg::COORD_W-1:0]    x_ff, x_in, y_ff, y_in;
   logic                                  edge_ff, edge_in;
   logic signed [msl_pkg::DIFF_W-1:0]     d_ff, d_in, dy_ff, dy_in;
   logic signed [msl_pkg::DIFF_W-1:0]     dxa_ff, dxa_in, dya_ff, dya_in;
   logic [msl_pkg::E_W-1:0]               e_ff, e_in;
   logic [msl_pkg::E_W-1:0]               len2_ff, len2_in;
   logic                                  hit_ff, hit_in;
   logic [msl_pkg::MIRROR_W-1:0]          id_ff, id_in;

   logic                                  quad;
   logic                                  is_x;
   logic                                  below;
   logic                                  fail;
   logic                                  skip;
   logic [msl_pkg::VERTEX_W-1:0]          corner;
   logic                                  axis;
   logic signed [msl_pkg::C_W-1:0]        c;
   logic signed [msl_pkg::C_W-1:0]        e;
   logic signed [msl_pkg::C_W-1:0]        e2;
   logic signed [msl_pkg::ACC_W-1:0]      thr;
   logic signed [msl_pkg::X2_W-1:0]       x2, sa, sb, m2;
   logic                                  x_ok;

   function automatic logic signed [msl_pkg::MUL_W-1:0] sext_d(
         input logic signed [msl_pkg::DIFF_W-1:0] v);
      sext_d = msl_pkg::MUL_W'(v);
   endfunction

   assign quad   = (mirror_ff == msl_pkg::QUAD_LO) || (mirror_ff == msl_pkg::QUAD_HI);
   assign is_x   = quad ? (job_ff == msl_pkg::QUAD_X_JOB) : (job_ff == msl_pkg::HEX_X_JOB);
   assign below  = msl_pkg::line_below(quad, job_ff);
   assign corner = msl_pkg::corner_sel(quad, job_ff, fcnt_ff[1:0]);
   assign axis   = is_x ? 1'b0 : fcnt_ff[0];
   assign rd_addr = base_ff + msl_pkg::ADDR_W'({corner, axis});

   assign skip = (mirror_ff == msl_pkg::SKIP_A) || (mirror_ff == msl_pkg::SKIP_B) ||
                 (mirror_ff == msl_pkg::SKIP_C) || (mirror_ff == msl_pkg::SKIP_D) ||
                 (edge_ff && mirror_ff == msl_pkg::AXIS_MIRROR) ||
                 (mirror_ff > msl_pkg::MIRROR_W'(22) && !(edge_ff && quad));

   // edge test arithmetic
   assign c   = acc[msl_pkg::C_W-1:0];
   assign e   = d_ff[msl_pkg::DIFF_W-1] ? -c : c;
   assign e2  = below ? -e : e;
   assign thr = msl_pkg::ACC_W'(len2_ff) << msl_pkg::SQ_SHIFT;

   // x bounds
   assign x2 = {x_ff[msl_pkg::COORD_W-1], x_ff, 1'b0};
   assign sa = msl_pkg::X2_W'(slot_ff[0]) + msl_pkg::X2_W'(slot_ff[1]);
   assign sb = msl_pkg::X2_W'(slot_ff[2]) + msl_pkg::X2_W'(slot_ff[3]);
   assign m2 = msl_pkg::X2_W'(msl_pkg::MARGIN2);

   always_comb begin
      if (!quad) begin
         x_ok = (x2 <= sb) && ((mirror_ff == msl_pkg::AXIS_MIRROR) ?
                               !x_ff[msl_pkg::COORD_W-1] : (x2 >= sa));
      end else if (mirror_ff == msl_pkg::QUAD_LO) begin
         x_ok = (x2 >= sa + m2) && (x2 <= sb - m2);
      end else begin
         x_ok = (x2 <= sa - m2) && (x2 >= sb + m2);
      end
   end

   always_comb begin
      mac_ctrl.mul_en = (state_ff == S_MUL);
      mac_ctrl.acc_en = (state_ff == S_ACC);
      mac_ctrl.op     = msl_pkg::ACC_LOAD;
      mac_ctrl.shift  = msl_pkg::SH_NONE;
      mac_ctrl.opa    = sext_d(dya_ff);
      mac_ctrl.opb    = sext_d(d_ff);
      case (step_ff)
         K_CX: begin
            mac_ctrl.opa = sext_d(dxa_ff);
            mac_ctrl.opb = sext_d(dy_ff);
            mac_ctrl.op  = msl_pkg::ACC_SUB;
         end
         K_DD: begin
            mac_ctrl.opa = sext_d(d_ff);
            mac_ctrl.opb = sext_d(d_ff);
         end
         K_YY: begin
            mac_ctrl.opa = sext_d(dy_ff);
            mac_ctrl.opb = sext_d(dy_ff);
            mac_ctrl.op  = msl_pkg::ACC_ADD;
         end
         K_HH: begin
            mac_ctrl.opa   = $signed({1'b0, e_ff[msl_pkg::E_W-1:msl_pkg::HALF_W]});
            mac_ctrl.opb   = $signed({1'b0, e_ff[msl_pkg::E_W-1:msl_pkg::HALF_W]});
            mac_ctrl.shift = msl_pkg::SH_FULL;
         end
         K_HL: begin
            mac_ctrl.opa   = $signed({1'b0, e_ff[msl_pkg::E_W-1:msl_pkg::HALF_W]});
            mac_ctrl.opb   = $signed({1'b0, e_ff[msl_pkg::HALF_W-1:0]});
            mac_ctrl.op    = msl_pkg::ACC_ADD;
            mac_ctrl.shift = msl_pkg::SH_HALF;
         end
         K_LL: begin
            mac_ctrl.opa = $signed({1'b0, e_ff[msl_pkg::HALF_W-1:0]});
            mac_ctrl.opb = $signed({1'b0, e_ff[msl_pkg::HALF_W-1:0]});
            mac_ctrl.op  = msl_pkg::ACC_ADD;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      mirror_in = mirror_ff;
      base_in   = base_ff;
      job_in    = job_ff;
      fcnt_in   = fcnt_ff;
      slot_in   = slot_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      edge_in   = edge_ff;
      d_in      = d_ff;
      dy_in     = dy_ff;
      dxa_in    = dxa_ff;
      dya_in    = dya_ff;
      e_in      = e_ff;
      len2_in   = len2_ff;
      hit_in    = hit_ff;
      id_in     = id_ff;
      fail      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               x_in      = cmd.query_x;
               y_in      = cmd.query_y;
               edge_in   = cmd.edge_flag;
               mirror_in = '0;
               base_in   = '0;
               state_in  = S_NEXT;
            end
         end
         S_NEXT: begin
            if (skip) begin
               fail = 1'b1;
            end else begin
               job_in   = '0;
               fcnt_in  = '0;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            if (fcnt_ff != 3'd0) begin
               slot_in[fcnt_ff[1:0] - 2'd1] = rd_data;
            end
            if (fcnt_ff == 3'd4) begin
               state_in = is_x ? S_XCHK : S_PREP;
            end else begin
               fcnt_in = fcnt_ff + 3'd1;
            end
         end
         S_PREP: begin
            d_in     = msl_pkg::DIFF_W'(slot_ff[0]) - msl_pkg::DIFF_W'(slot_ff[2]);
            dy_in    = msl_pkg::DIFF_W'(slot_ff[1]) - msl_pkg::DIFF_W'(slot_ff[3]);
            dxa_in   = msl_pkg::DIFF_W'(x_ff) - msl_pkg::DIFF_W'(slot_ff[0]);
            dya_in   = msl_pkg::DIFF_W'(y_ff) - msl_pkg::DIFF_W'(slot_ff[1]);
            step_in  = K_CY;
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_MUL;
            case (step_ff)
               K_CY: step_in = K_CX;
               K_CX: begin
                  if (d_ff == '0) begin
                     fail = 1'b1;
                  end else if (!quad) begin
                     if (below ? (!e[msl_pkg::C_W-1] && e != '0) : e[msl_pkg::C_W-1]) begin
                        fail = 1'b1;
                     end else begin
                        job_in   = job_ff + 3'd1;
                        fcnt_in  = '0;
                        state_in = S_FETCH;
                     end
                  end else if (e2[msl_pkg::C_W-1]) begin
                     fail = 1'b1;
                  end else begin
                     e_in    = msl_pkg::E_W'(e2);
                     step_in = K_DD;
                  end
               end
               K_DD: step_in = K_YY;
               K_YY: begin
                  len2_in = acc[msl_pkg::E_W-1:0];
                  step_in = K_HH;
               end
               K_HH: step_in = K_HL;
               K_HL: step_in = K_LL;
               default: begin
                  if (acc >= thr) begin
                     job_in   = job_ff + 3'd1;
                     fcnt_in  = '0;
                     state_in = S_FETCH;
                  end else begin
                     fail = 1'b1;
                  end
               end
            endcase
         end
         S_XCHK: begin
            if (x_ok) begin
               hit_in   = 1'b1;
               id_in    = mirror_ff;
               state_in = S_DONE;
            end else begin
               fail = 1'b1;
            end
         end
         S_DONE: begin
            if (res_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // move on to the next mirror, or report a miss after the last one
      if (fail) begin
         if (mirror_ff == msl_pkg::LAST_MIRROR) begin
            hit_in   = 1'b0;
            id_in    = '0;
            state_in = S_DONE;
         end else begin
            mirror_in = mirror_ff + msl_pkg::MIRROR_W'(1);
            base_in   = base_ff + msl_pkg::ADDR_W'(msl_pkg::MIRROR_STRIDE);
            state_in  = S_NEXT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff   <= step_in;
      mirror_ff <= mirror_in;
      base_ff   <= base_in;
      job_ff    <= job_in;
      fcnt_ff   <= fcnt_in;
      slot_ff   <= slot_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      edge_ff   <= edge_in;
      d_ff      <= d_in;
      dy_ff     <= dy_in;
      dxa_ff    <= dxa_in;
      dya_ff    <= dya_in;
      e_ff      <= e_in;
      len2_ff   <= len2_in;
      hit_ff    <= hit_in;
      id_ff     <= id_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign res.done      = (state_ff == S_DONE) && res_free;
   assign res.hit       = hit_ff;
   assign res.mirror_id = id_ff;

`ifndef SYNTHESIS
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.start && state_ff == S_IDLE |=> state_ff == S_NEXT)
      else $error("query start not taken");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      res.done |=> state_ff == S_IDLE)
      else $error("sequencer did not return to idle");
   a_miss_id: assert property (@(posedge clock) disable iff (reset)
      res.done && !res.hit |-> res.mirror_id == '0)
      else $error("miss with nonzero mirror id");
   a_fetch_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FETCH |-> fcnt_ff <= 3'd4)
      else $error("fetch counter out of range");
`endif

endmodule

>>> rtl/mirror_segment_locator_unit.sv
// loads: a load word is written into the corner table when it is taken; a query result
// follows each query word once the mirrors up to the hit, or all on a miss, are skipped or tested
// throughput: one query at a time, bound by the single shared multiplier and one
// corner memory read per cycle; loads are taken back to back while no query is running
// reset: control state cleared at once; the corner table is undefined until loaded
// ---------------------------------------------------------------------------
// mirror_segment_locator_unit
// Finds the first mirror outline holding a query point from a loaded corner table.
// ---------------------------------------------------------------------------
module mirror_segment_locator_unit (
   input  logic         clock,
   input  logic         reset,
   msl_req_if.sink      req_chan,
   msl_rsp_if.source    rsp_chan
);

   logic                                 req_take;
   logic                                 busy;
   logic                                 wr_en;
   logic [msl_pkg::ADDR_W-1:0]           wr_addr;
   logic [msl_pkg::ADDR_W-1:0]           rd_addr;
   logic [msl_pkg::COORD_W-1:0]          rd_data;
   logic                                 res_free;
   msl_pkg::seq_cmd_type                 cmd;
   msl_pkg::seq_res_type                 res;
   msl_pkg::mac_ctrl_type                mac_ctrl;
   logic signed [msl_pkg::ACC_W-1:0]     acc;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_hit_ff, rsp_hit_in;
   logic [msl_pkg::MIRROR_W-1:0]         rsp_id_ff, rsp_id_in;

   assign req_chan.ready = !busy;
   assign req_take       = req_chan.valid && req_chan.ready;

   // corner table write
   assign wr_en = req_take && (req_chan.func == msl_pkg::FUNC_LOAD) &&
                  (int'(req_chan.mirror_index) < msl_pkg::NUM_MIRRORS) &&
                  (int'(req_chan.vertex_index) < msl_pkg::CORNERS_PER_MIRROR);
   assign wr_addr = msl_pkg::ADDR_W'(req_chan.mirror_index) *
                       msl_pkg::ADDR_W'(msl_pkg::MIRROR_STRIDE) +
                    msl_pkg::ADDR_W'({req_chan.vertex_index, req_chan.axis_select});

   assign cmd.start     = req_take && (req_chan.func == msl_pkg::FUNC_QUERY);
   assign cmd.query_x   = req_chan.query_x;
   assign cmd.query_y   = req_chan.query_y;
   assign cmd.edge_flag = req_chan.edge_flag;

   msl_ram #(
      .WIDTH (msl_pkg::COORD_W),
      .DEPTH (msl_pkg::TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_chan.load_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   msl_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .acc   (acc)
   );

   msl_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .res_free (res_free),
      .res      (res),
      .busy     (busy),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .mac_ctrl (mac_ctrl),
      .acc      (acc)
   );

   // result word register
   assign res_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_id_in    = rsp_id_ff;
      if (res.done) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = res.hit;
         rsp_id_in    = res.mirror_id;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_hit_ff <= rsp_hit_in;
      rsp_id_ff  <= rsp_id_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.hit       = rsp_hit_ff;
   assign rsp_chan.mirror_id = rsp_id_ff;

`ifndef SYNTHESIS
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !busy)
      else $error("table write during a query");
   a_done_room: assert property (@(posedge clock) disable iff (reset)
      res.done |=> rsp_valid_ff)
      else $error("result word lost");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res.done |-> res_free)
      else $error("result word overwritten");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Loads corner tables into the mirror segment locator and checks every query
// result against a behavioral predictor, under random idling and back pressure.
// ---------------------------------------------------------------------------
module testbench;

   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;
   localparam longint GRID = 102400;
   localparam longint HALF_W = 38400;
   localparam longint HALF_R = 43520;
   localparam longint MARGIN = 4 << msl_pkg::COORD_FRAC_BITS;

   typedef struct packed {
      logic                               func;
      logic [msl_pkg::MIRROR_W-1:0]       mirror_index;
      logic [msl_pkg::VERTEX_W-1:0]       vertex_index;
      logic                               axis_select;
      logic signed [msl_pkg::COORD_W-1:0] load_value;
      logic signed [msl_pkg::COORD_W-1:0] query_x;
      logic signed [msl_pkg::COORD_W-1:0] query_y;
      logic                               edge_flag;
   } req_word_type;

   typedef struct packed {
      logic                         hit;
      logic [msl_pkg::MIRROR_W-1:0] mirror_id;
   } locate_result_type;

   logic clock;
   logic reset;

   msl_req_if req_chan ();
   msl_rsp_if rsp_chan ();

   mirror_segment_locator_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   longint corner_x [msl_pkg::NUM_MIRRORS][msl_pkg::CORNERS_PER_MIRROR];
   longint corner_y [msl_pkg::NUM_MIRRORS][msl_pkg::CORNERS_PER_MIRROR];
   locate_result_type expected_locations [$];
   int errors = 0;
   int n_loads;
   int n_queries;
   int n_hits;
   int sender_idle_pct;
   int receiver_stall_pct;
   logic hold_on;
   event hold_go;

   // ---------------- predictor ----------------
   function automatic int side_of_line(longint ax, longint ay, longint bx, longint by,
                                       longint x, longint y);
      longint d;
      longint c;
      int s;
      d = ax - bx;
      if (d == 0) return 2;
      c = (y - ay) * d - (x - ax) * (ay - by);
      s = (c > 0) ? 1 : ((c < 0) ? -1 : 0);
      return (d > 0) ? s : -s;
   endfunction

   function automatic bit clears_line(longint ax, longint ay, longint bx, longint by,
                                      longint x, longint y, bit below);
      longint d;
      longint dy;
      longint e;
      logic [127:0] ee;
      logic [127:0] len2;
      d  = ax - bx;
      dy = ay - by;
      if (d == 0) return 1'b0;
      e = (y - ay) * d - (x - ax) * dy;
      if (d < 0) e = -e;
      if (below) e = -e;
      if (e < 0) return 1'b0;
      ee   = 128'(e);
      len2 = 128'(d * d) + 128'(dy * dy);
      return (ee * ee) >= (128'(MARGIN * MARGIN) * len2);
   endfunction

   function automatic bit in_hexagon(int m, longint x, longint y);
      int s1, s3, s4, s6;
      bit left;
      s1 = side_of_line(corner_x[m][0], corner_y[m][0], corner_x[m][1], corner_y[m][1], x, y);
      s3 = side_of_line(corner_x[m][2], corner_y[m][2], corner_x[m][3], corner_y[m][3], x, y);
      s4 = side_of_line(corner_x[m][3], corner_y[m][3], corner_x[m][4], corner_y[m][4], x, y);
      s6 = side_of_line(corner_x[m][5], corner_y[m][5], corner_x[m][0], corner_y[m][0], x, y);
      if (s1 == 2 || s3 == 2 || s4 == 2 || s6 == 2) return 1'b0;
      if (m == msl_pkg::AXIS_MIRROR) left = (x >= 0);
      else left = (2 * x >= corner_x[m][4] + corner_x[m][5]);
      return s1 <= 0 && s3 >= 0 && s4 >= 0 && s6 <= 0 &&
             2 * x <= corner_x[m][1] + corner_x[m][2] && left;
   endfunction

   function automatic bit in_quad(int m, longint x, longint y);
      longint s03;
      longint s12;
      s03 = corner_x[m][0] + corner_x[m][3];
      s12 = corner_x[m][1] + corner_x[m][2];
      if (!clears_line(corner_x[m][1], corner_y[m][1], corner_x[m][0], corner_y[m][0],
                       x, y, 1'b1)) return 1'b0;
      if (!clears_line(corner_x[m][3], corner_y[m][3], corner_x[m][2], corner_y[m][2],
                       x, y, 1'b0)) return 1'b0;
      if (m == msl_pkg::QUAD_LO)
         return (2 * x >= s03 + 2 * MARGIN) && (2 * x <= s12 - 2 * MARGIN);
      return (2 * x <= s03 - 2 * MARGIN) && (2 * x >= s12 + 2 * MARGIN);
   endfunction

   function automatic locate_result_type locate_point(longint x, longint y, bit edge_on);
      locate_result_type r;
      r = '0;
      for (int m = 0; m < msl_pkg::NUM_MIRRORS; m++) begin
         if (m == msl_pkg::SKIP_A || m == msl_pkg::SKIP_B ||
             m == msl_pkg::SKIP_C || m == msl_pkg::SKIP_D) continue;
         if (edge_on && m == msl_pkg::AXIS_MIRROR) continue;
         if (m < msl_pkg::QUAD_LO) begin
            if (in_hexagon(m, x, y)) begin
               r.hit = 1'b1; r.mirror_id = msl_pkg::MIRROR_W'(m); return r;
            end
         end else if (edge_on) begin
            if (in_quad(m, x, y)) begin
               r.hit = 1'b1; r.mirror_id = msl_pkg::MIRROR_W'(m); return r;
            end
         end
      end
      return r;
   endfunction

   // ---------------- sender ----------------
   task automatic send_word(input req_word_type w);
      locate_result_type r;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.func         <= w.func;
      req_chan.mirror_index <= w.mirror_index;
      req_chan.vertex_index <= w.vertex_index;
      req_chan.axis_select  <= w.axis_select;
      req_chan.load_value   <= w.load_value;
      req_chan.query_x      <= w.query_x;
      req_chan.query_y      <= w.query_y;
      req_chan.edge_flag    <= w.edge_flag;
      do @(posedge clock); while (!req_chan.ready);
      if (w.func == msl_pkg::FUNC_LOAD) begin
         n_loads++;
         if (w.mirror_index < msl_pkg::NUM_MIRRORS &&
             w.vertex_index < msl_pkg::CORNERS_PER_MIRROR) begin
            if (w.axis_select == AXIS_X)
               corner_x[w.mirror_index][w.vertex_index] = longint'(w.load_value);
            else
               corner_y[w.mirror_index][w.vertex_index] = longint'(w.load_value);
         end
      end else begin
         n_queries++;
         r = locate_point(longint'(w.query_x), longint'(w.query_y), w.edge_flag);
         if (r.hit) n_hits++;
         expected_locations.push_back(r);
      end
   endtask

   function automatic req_word_type random_word();
      req_word_type w;
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      w = raw[$bits(req_word_type)-1:0];
      return w;
   endfunction

   task automatic load_coord(int m, int v, bit axis, longint value);
      req_word_type w;
      w = random_word();
      w.func         = msl_pkg::FUNC_LOAD;
      w.mirror_index = msl_pkg::MIRROR_W'(m);
      w.vertex_index = msl_pkg::VERTEX_W'(v);
      w.axis_select  = axis;
      w.load_value   = msl_pkg::COORD_W'(value);
      send_word(w);
   endtask

   task automatic query(longint x, longint y, bit edge_on);
      req_word_type w;
      w = random_word();
      w.func      = msl_pkg::FUNC_QUERY;
      w.query_x   = msl_pkg::COORD_W'(x);
      w.query_y   = msl_pkg::COORD_W'(y);
      w.edge_flag = edge_on;
      send_word(w);
   endtask

   function automatic longint center_x(int m);
      return (m % 5 - 2) * GRID;
   endfunction

   function automatic longint center_y(int m);
      return (m / 5 - 2) * GRID;
   endfunction

   // nominal outline of mirror m, corners moved by up to jit
   task automatic load_mirror(int m, int jit);
      longint px [6];
      longint py [6];
      longint cxm, cym;
      cxm = center_x(m);
      cym = center_y(m);
      if (m >= msl_pkg::QUAD_LO) begin
         px = '{cxm - HALF_W, cxm + HALF_W, cxm + HALF_W, cxm - HALF_W, cxm, cxm};
         py = '{cym + HALF_W, cym + HALF_W, cym - HALF_W, cym - HALF_W, cym, cym};
         if (m == msl_pkg::QUAD_HI) for (int v = 0; v < 4; v++) px[v] = 2 * cxm - px[v];
      end else begin
         px = '{cxm, cxm + HALF_W, cxm + HALF_W, cxm, cxm - HALF_W, cxm - HALF_W};
         py = '{cym + HALF_R, cym + HALF_R / 2, cym - HALF_R / 2, cym - HALF_R,
                cym - HALF_R / 2, cym + HALF_R / 2};
      end
      for (int v = 0; v < msl_pkg::CORNERS_PER_MIRROR; v++) begin
         load_coord(m, v, AXIS_X, px[v] + $signed($urandom_range(2 * jit)) - jit);
         load_coord(m, v, AXIS_Y, py[v] + $signed($urandom_range(2 * jit)) - jit);
      end
   endtask

   task automatic load_table(int jit);
      for (int m = 0; m < msl_pkg::NUM_MIRRORS; m++) load_mirror(m, jit);
   endtask

   task automatic wait_drained();
      while (expected_locations.size() != 0) @(posedge clock);
   endtask

   // ---------------- long receiver hold-off ----------------
   initial begin
      hold_on = 1'b0;
      forever begin
         @(hold_go);
         hold_on <= 1'b1;
         repeat (4000) @(posedge clock);
         hold_on <= 1'b0;
      end
   end

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      locate_result_type exp_r;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_locations.size() == 0) begin
            $display("%0t unexpected result: hit %0b mirror %0d", $time,
                     rsp_chan.hit, rsp_chan.mirror_id);
            errors++;
         end else begin
            exp_r = expected_locations.pop_front();
            if (rsp_chan.hit !== exp_r.hit || rsp_chan.mirror_id !== exp_r.mirror_id) begin
               $display("%0t mismatch: expected hit %0b mirror %0d, got hit %0b mirror %0d",
                        $time, exp_r.hit, exp_r.mirror_id, rsp_chan.hit, rsp_chan.mirror_id);
               errors++;
            end
         end
      end
      rsp_chan.ready <= !hold_on && ($urandom_range(99) >= receiver_stall_pct);
   end

   // ---------------- tests ----------------
   task automatic test_table_load();
      load_table(0);
      // out of range words are dropped by the block
      load_coord(31, 0, AXIS_X, -8388608);
      load_coord(25, 3, AXIS_Y, 8388607);
      load_coord(4, 6, AXIS_X, 0);
      load_coord(9, 7, AXIS_Y, -1);
   endtask

   task automatic test_directed_queries();
      query(center_x(1), center_y(1), 1'b0);
      query(center_x(msl_pkg::AXIS_MIRROR), center_y(msl_pkg::AXIS_MIRROR), 1'b0);
      query(0, center_y(msl_pkg::AXIS_MIRROR), 1'b0);
      query(-1, center_y(msl_pkg::AXIS_MIRROR), 1'b0);
      query(center_x(msl_pkg::AXIS_MIRROR) + 100, center_y(msl_pkg::AXIS_MIRROR), 1'b1);
      query(center_x(msl_pkg::SKIP_B), center_y(msl_pkg::SKIP_B), 1'b0);
      query(center_x(msl_pkg::SKIP_C), center_y(msl_pkg::SKIP_C), 1'b1);
      query(center_x(msl_pkg::SKIP_A), center_y(msl_pkg::SKIP_A), 1'b0);
      query(center_x(msl_pkg::QUAD_LO), center_y(msl_pkg::QUAD_LO), 1'b0);
      query(center_x(msl_pkg::QUAD_LO), center_y(msl_pkg::QUAD_LO), 1'b1);
      query(center_x(msl_pkg::QUAD_HI), center_y(msl_pkg::QUAD_HI), 1'b1);
      // exactly on the margin, then just inside it
      query(center_x(msl_pkg::QUAD_LO) - HALF_W + MARGIN, center_y(msl_pkg::QUAD_LO), 1'b1);
      query(center_x(msl_pkg::QUAD_LO) - HALF_W + MARGIN - 1, center_y(msl_pkg::QUAD_LO),
            1'b1);
      query(center_x(msl_pkg::QUAD_LO), center_y(msl_pkg::QUAD_LO) + HALF_W - MARGIN, 1'b1);
      query(center_x(msl_pkg::QUAD_LO), center_y(msl_pkg::QUAD_LO) + HALF_W - MARGIN + 1,
            1'b1);
      query(center_x(msl_pkg::QUAD_HI) + HALF_W - MARGIN, center_y(msl_pkg::QUAD_HI), 1'b1);
      // on and just beyond the hexagon boundary
      query(center_x(6) + HALF_W, center_y(6), 1'b0);
      query(center_x(6) + HALF_W + 1, center_y(6), 1'b0);
      query(center_x(6), center_y(6) + HALF_R, 1'b0);
      query(-8388608, -8388608, 1'b0);
      query(8388607, 8388607, 1'b1);
      query(-8388608, 8388607, 1'b1);
      query(8388607, -8388608, 1'b0);
   endtask

   task automatic test_vertical_edges();
      load_coord(1, 1, AXIS_X, center_x(1));
      query(center_x(1), center_y(1), 1'b0);
      load_coord(msl_pkg::QUAD_LO, 0, AXIS_X, corner_x[msl_pkg::QUAD_LO][1]);
      query(center_x(msl_pkg::QUAD_LO), center_y(msl_pkg::QUAD_LO), 1'b1);
      // extreme corners on mirror 3
      load_coord(3, 0, AXIS_X, -8388608);
      load_coord(3, 1, AXIS_X, 8388607);
      load_coord(3, 0, AXIS_Y, 8388607);
      load_coord(3, 1, AXIS_Y, -8388608);
      query(0, 0, 1'b0);
      query(8388607, -8388608, 1'b0);
      load_table(0);
   endtask

   task automatic random_queries(int count);
      int m;
      for (int i = 0; i < count; i++) begin
         m = $urandom_range(msl_pkg::NUM_MIRRORS - 1);
         if ($urandom_range(9) < 8)
            query(center_x(m) + $signed($urandom_range(2 * 48000)) - 48000,
                  center_y(m) + $signed($urandom_range(2 * 48000)) - 48000,
                  $urandom_range(1));
         else
            query(longint'($signed(msl_pkg::COORD_W'($urandom))),
                  longint'($signed(msl_pkg::COORD_W'($urandom))), $urandom_range(1));
      end
   endtask

   task automatic random_reload();
      int m;
      if ($urandom_range(3) == 0) begin
         // noise outline on a few mirrors
         for (int k = 0; k < 3; k++) begin
            m = $urandom_range(msl_pkg::NUM_MIRRORS - 1);
            for (int v = 0; v < msl_pkg::CORNERS_PER_MIRROR; v++) begin
               load_coord(m, v, AXIS_X, longint'($signed(msl_pkg::COORD_W'($urandom))));
               load_coord(m, v, AXIS_Y, longint'($signed(msl_pkg::COORD_W'($urandom))));
            end
         end
      end
      load_mirror($urandom_range(msl_pkg::NUM_MIRRORS - 1), 3000);
   endtask

   task automatic test_idle_phases();
      int snd [4] = '{0, 68, 0, 31};
      int rcv [4] = '{0, 0, 68, 31};
      for (int p = 0; p < 4; p++) begin
         sender_idle_pct    = snd[p];
         receiver_stall_pct = rcv[p];
         for (int k = 0; k < 5; k++) begin
            random_reload();
            random_queries(14);
         end
      end
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
   endtask

   task automatic test_backpressure();
      @(posedge clock);
      -> hold_go;
      random_queries(20);
      req_chan.valid <= 1'b0;
      wait_drained();
   endtask

   initial begin
      n_loads = 0;
      n_queries = 0;
      n_hits = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.func = msl_pkg::FUNC_LOAD;
      req_chan.mirror_index = '0;
      req_chan.vertex_index = '0;
      req_chan.axis_select = AXIS_X;
      req_chan.load_value = '0;
      req_chan.query_x = '0;
      req_chan.query_y = '0;
      req_chan.edge_flag = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_load();
      test_directed_queries();
      test_vertical_edges();
      test_idle_phases();
      test_backpressure();
      wait_drained();
      repeat (1200) @(posedge clock);
      $display("covered %0d load words and %0d queries (%0d hits) over nominal, jittered",
               n_loads, n_queries, n_hits);
      $display("and noisy corner tables with idle, stall and long hold-off phases");
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("timeout with %0d results outstanding", expected_locations.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
